// ===== hw/rtl/max_sum_lis_tracker_assert.svh =====
// Assertion macros shared by the tracker RTL.
// Included by modules that carry concurrent checks.
`ifndef MAX_SUM_LIS_TRACKER_ASSERT_SVH
`define MAX_SUM_LIS_TRACKER_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define MSL_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define MSL_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== hw/rtl/msl_pkg.sv =====
// Package for the tracker: widths, record type, state codes, ranking function.
// No dependencies.
`default_nettype none
package msl_pkg;
  localparam int MaxValuesDef = 1024;
  localparam int ValW = 11;
  localparam int LenW = 11;
  localparam int SumW = 20;
  localparam int IdxW = 11;

  typedef struct packed {
    logic [LenW-1:0] len;
    logic [SumW-1:0] sum;
    logic [IdxW-1:0] idx;
  } rec_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLEAR, ST_QRD, ST_QCMP, ST_URD, ST_UWR, ST_UUP, ST_OUT
  } state_t;

  function automatic logic ranks_above(rec_t a, rec_t b);
    if (a.len != b.len) return a.len > b.len;
    return a.sum > b.sum;
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/msl_in_if.sv =====
// Valid/ready channel interface for input items.
// Uses msl_pkg for field widths.
`default_nettype none
interface msl_in_if;
  import msl_pkg::*;
  logic            valid;
  logic            ready;
  logic [ValW-1:0] value;
  logic            start_new;
  modport source(output valid, value, start_new, input ready);
  modport sink(input valid, value, start_new, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/msl_out_if.sv =====
// Result channel interface.
// Uses msl_pkg for field widths.
`default_nettype none
interface msl_out_if;
  import msl_pkg::*;
  logic            valid;
  logic            ready;
  logic [IdxW-1:0] item_index;
  logic [LenW-1:0] chain_length;
  logic [SumW-1:0] chain_sum;
  logic [IdxW-1:0] predecessor_index;
  logic [LenW-1:0] best_length;
  logic [SumW-1:0] best_sum;
  logic [IdxW-1:0] best_end_index;
  logic            rejected;
  modport source(output valid, item_index, chain_length, chain_sum, predecessor_index,
                 best_length, best_sum, best_end_index, rejected, input ready);
  modport sink(input valid, item_index, chain_length, chain_sum, predecessor_index,
               best_length, best_sum, best_end_index, rejected, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/msl_tree_mem.sv =====
// Segment tree node memory: one write port, one registered read port.
// Uses msl_pkg for the record type.
`default_nettype none
module msl_tree_mem #(
  parameter int AW = 11
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire msl_pkg::rec_t   wdata,
  input  wire logic [AW-1:0]   raddr,
  output msl_pkg::rec_t        rdata
);
  import msl_pkg::*;
  rec_t mem [2**AW];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/max_sum_lis_tracker.sv =====
// Longest increasing chain with maximum sum over a value stream.
// Each item walks the tree from its leaf up (L = tree depth, 10 at 1024 values), with
// a read and a compare phase per level, then updates the leaf and rebuilds each parent.
// A rejected item skips both walks; a new item is taken only after the prior result.
// Reset clears counter and best, then sweeps the tree memory one node per cycle;
// start_new repeats that sweep before its item.
`default_nettype none
module max_sum_lis_tracker #(
  parameter int MAX_VALUES = msl_pkg::MaxValuesDef
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [msl_pkg::ValW-1:0] cfg_wdata,
  msl_in_if.sink                      in_ch,
  msl_out_if.source                   out_ch
);
  import msl_pkg::*;
  `include "max_sum_lis_tracker_assert.svh"

  localparam int L  = $clog2(MAX_VALUES);
  localparam int AW = L + 1;
  localparam int CW = $clog2(MAX_VALUES + 1);
  localparam logic [AW-1:0] LEAF0 = AW'(1) << L;
  localparam int DomMax = (1 << ValW) - 1;
  localparam int DomCap = (MAX_VALUES < DomMax) ? MAX_VALUES : DomMax;

  state_t st_r, st_nxt;
  logic [ValW-1:0] dom_r;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  rec_t            best_r, best_nxt, acc_r, acc_nxt, cur_r, cur_nxt;
  rec_t            chv_r, chv_nxt;     // record now held by the update node
  logic [ValW-1:0] x_r, x_nxt;
  logic [AW-1:0]   node_r, node_nxt;   // query walk node / update node
  logic [L:0]      lvl_r, lvl_nxt;
  logic            rej_r, rej_nxt, init_r, init_nxt;
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  rec_t            wdata, rdata, mx, par;
  logic [L:0]      key;                // x-1 as leaf offset (x-1 < MAX_VALUES)
  logic            okv;
  logic [ValW-1:0] domc;

  msl_tree_mem #(.AW(AW)) u_mem (.clk, .we, .waddr, .wdata, .raddr, .rdata);

  always_ff @(posedge clk) begin
    if (!rst_n) dom_r <= ValW'(1024);
    else if (cfg_we) dom_r <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR; clr_r <= '0; cnt_r <= '0; best_r <= '0; init_r <= 1'b1;
    end else begin
      st_r <= st_nxt; clr_r <= clr_nxt; cnt_r <= cnt_nxt; best_r <= best_nxt;
      init_r <= init_nxt;
    end
    acc_r <= acc_nxt; cur_r <= cur_nxt; x_r <= x_nxt; node_r <= node_nxt;
    lvl_r <= lvl_nxt; rej_r <= rej_nxt; chv_r <= chv_nxt;
  end

  assign domc = (dom_r > ValW'(DomCap)) ? ValW'(DomCap) : dom_r;
  assign key  = (L+1)'(x_r - ValW'(1));
  // Left-first max over two records (tie keeps a).
  function automatic rec_t pick(rec_t a, rec_t b);
    return ranks_above(b, a) ? b : a;
  endfunction
  assign mx = pick(rdata, acc_r);
  // Parent of the update node: the left child wins a tie.
  assign par = node_r[0] ? pick(rdata, chv_r) : pick(chv_r, rdata);

  always_comb begin
    st_nxt = st_r; clr_nxt = clr_r; cnt_nxt = cnt_r; best_nxt = best_r;
    acc_nxt = acc_r; cur_nxt = cur_r; x_nxt = x_r; node_nxt = node_r;
    lvl_nxt = lvl_r; rej_nxt = rej_r; init_nxt = init_r; chv_nxt = chv_r;
    we = 1'b0; waddr = clr_r; wdata = '0; raddr = node_r;
    in_ch.ready = 1'b0; out_ch.valid = 1'b0;
    okv = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          x_nxt = in_ch.value;
          if (in_ch.start_new) begin
            cnt_nxt = '0; best_nxt = '0; clr_nxt = '0; st_nxt = ST_CLEAR;
          end else st_nxt = ST_QRD;
        end
      end
      ST_CLEAR: begin
        we = 1'b1; waddr = clr_r; clr_nxt = clr_r + AW'(1);
        if (clr_r == '1) st_nxt = init_r ? ST_IDLE : ST_QRD;
        if (clr_r == '1) init_nxt = 1'b0;
      end
      ST_QRD: begin
        okv = (x_r != '0) && (x_r <= domc) && (cnt_r < CW'(MAX_VALUES));
        rej_nxt = !okv; acc_nxt = '0;
        // Walk from leaf key upward; collect left siblings when we are a right child.
        node_nxt = LEAF0 | AW'(key);
        lvl_nxt = '0;
        st_nxt = okv ? ST_QCMP : ST_OUT;
        if (okv) cnt_nxt = cnt_r + CW'(1);
      end
      ST_QCMP: begin
        // Phase: address (node^1) read issued on each level; its data is used when node is right child.
        raddr = node_r ^ AW'(1);
        if (lvl_r[0]) begin
          // order: rdata covers values left of acc's range, so left wins ties
          if (node_r[0] && node_r != AW'(1)) acc_nxt = pick(rdata, acc_r);
          node_nxt = node_r >> 1;
          if (node_r == AW'(1) || (node_r >> 1) == AW'(1)) begin
            cur_nxt.len = acc_r.len + LenW'(1);
            cur_nxt.sum = acc_r.sum + SumW'(x_r);
            cur_nxt.idx = IdxW'(cnt_r);
            if (node_r[0] && node_r != AW'(1)) begin
              cur_nxt.len = mx.len + LenW'(1);
              cur_nxt.sum = mx.sum + SumW'(x_r);
              acc_nxt = mx;
            end
            node_nxt = LEAF0 | AW'(key);
            st_nxt = ST_URD;
          end
        end
        lvl_nxt = lvl_r + (L+1)'(1);
      end
      ST_URD: begin
        raddr = node_r; st_nxt = ST_UWR;
      end
      ST_UWR: begin
        // The leaf keeps its old record only if that ranks strictly above the new chain.
        raddr = node_r ^ AW'(1);
        if (!ranks_above(rdata, cur_r)) begin
          we = 1'b1; waddr = node_r; wdata = cur_r; chv_nxt = cur_r;
        end else chv_nxt = rdata;
        st_nxt = ST_UUP;
      end
      ST_UUP: begin
        // Each parent is rebuilt from both children; the sibling read was issued last cycle.
        we = 1'b1; waddr = node_r >> 1; wdata = par; chv_nxt = par;
        node_nxt = node_r >> 1;
        raddr = (node_r >> 1) ^ AW'(1);
        if ((node_r >> 1) == AW'(1)) begin
          if (!ranks_above(best_r, cur_r)) best_nxt = cur_r;
          st_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign out_ch.item_index        = rej_r ? '0 : cur_r.idx;
  assign out_ch.chain_length      = rej_r ? '0 : cur_r.len;
  assign out_ch.chain_sum         = rej_r ? '0 : cur_r.sum;
  assign out_ch.predecessor_index = rej_r ? '0 : acc_r.idx;
  assign out_ch.best_length       = best_r.len;
  assign out_ch.best_sum          = best_r.sum;
  assign out_ch.best_end_index    = best_r.idx;
  assign out_ch.rejected          = rej_r;

  `MSL_ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ch.ready, st_r == ST_IDLE)
  `MSL_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(MAX_VALUES))
  `MSL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
endmodule
`default_nettype wire
